@@ design/roi_mean_range_occlusion_check_core_defines.svh @@
// Assertion macros for the ROI mean range occlusion check core.
// Expects signals named clock and reset in the including scope.
`ifndef ROI_MEAN_RANGE_OCCLUSION_CHECK_CORE_DEFINES_SVH
`define ROI_MEAN_RANGE_OCCLUSION_CHECK_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define ROI_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ROI_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ design/roi_pkg.sv @@
// Shared types and constants of the ROI mean range occlusion check core.
// No dependencies; used by every module of the block.
package roi_pkg;

   localparam int COORD_W    = 24;
   localparam int PIXEL_W    = 16;
   localparam int RANGE_W    = 24;
   localparam int SQ_W       = 48;
   localparam int SUM_W      = 41;
   localparam int TALLY_W    = 17;
   localparam int UNIT_W     = 27;
   localparam int STEP_W     = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [TALLY_W-1:0] MAX_POINTS = 17'd65536;
   localparam int ROOT_STEPS = SQ_W / 2;
   localparam int DIV_STEPS  = SUM_W;

   localparam logic [PIXEL_W-1:0] BOX_LOW_RESET  = 16'd0;
   localparam logic [PIXEL_W-1:0] BOX_HIGH_RESET = 16'd65535;
   localparam logic [RANGE_W-1:0] EXPECTED_RESET = 24'd0;
   localparam logic [RANGE_W-1:0] TOL_RESET      = 24'd500;

   typedef enum logic [2:0] {
      CSR_BOX_U_LOW  = 3'd0,
      CSR_BOX_U_HIGH = 3'd1,
      CSR_BOX_V_LOW  = 3'd2,
      CSR_BOX_V_HIGH = 3'd3,
      CSR_EXPECTED   = 3'd4,
      CSR_TOLERANCE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] box_u_low;
      logic [PIXEL_W-1:0] box_u_high;
      logic [PIXEL_W-1:0] box_v_low;
      logic [PIXEL_W-1:0] box_v_high;
      logic [RANGE_W-1:0] expected_distance;
      logic [RANGE_W-1:0] range_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [UNIT_W-1:0] diff;
      logic              fits;
   } trial_type;

endpackage

@@ design/roi_csr.sv @@
// Configuration register file with an APB-style access port.
// Depends on roi_pkg for the register map and the configuration struct.
module roi_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [roi_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [roi_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [roi_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output roi_pkg::cfg_type                   cfg
);

   roi_pkg::cfg_type cfg_ff;
   roi_pkg::cfg_type cfg_in;
   logic             write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (paddr[4:2])
            roi_pkg::CSR_BOX_U_LOW:  cfg_in.box_u_low  = pwdata[15:0];
            roi_pkg::CSR_BOX_U_HIGH: cfg_in.box_u_high = pwdata[15:0];
            roi_pkg::CSR_BOX_V_LOW:  cfg_in.box_v_low  = pwdata[15:0];
            roi_pkg::CSR_BOX_V_HIGH: cfg_in.box_v_high = pwdata[15:0];
            roi_pkg::CSR_EXPECTED:   cfg_in.expected_distance = pwdata[23:0];
            roi_pkg::CSR_TOLERANCE:  cfg_in.range_tolerance   = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         roi_pkg::CSR_BOX_U_LOW:  prdata = {16'd0, cfg_ff.box_u_low};
         roi_pkg::CSR_BOX_U_HIGH: prdata = {16'd0, cfg_ff.box_u_high};
         roi_pkg::CSR_BOX_V_LOW:  prdata = {16'd0, cfg_ff.box_v_low};
         roi_pkg::CSR_BOX_V_HIGH: prdata = {16'd0, cfg_ff.box_v_high};
         roi_pkg::CSR_EXPECTED:   prdata = {8'd0, cfg_ff.expected_distance};
         roi_pkg::CSR_TOLERANCE:  prdata = {8'd0, cfg_ff.range_tolerance};
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_u_low         <= roi_pkg::BOX_LOW_RESET;
         cfg_ff.box_u_high        <= roi_pkg::BOX_HIGH_RESET;
         cfg_ff.box_v_low         <= roi_pkg::BOX_LOW_RESET;
         cfg_ff.box_v_high        <= roi_pkg::BOX_HIGH_RESET;
         cfg_ff.expected_distance <= roi_pkg::EXPECTED_RESET;
         cfg_ff.range_tolerance   <= roi_pkg::TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/roi_square.sv @@
// Registered squarer for one coordinate magnitude per cycle.
// Depends on roi_pkg for the operand and product widths.
module roi_square (
   input  logic                          clock,
   input  logic [roi_pkg::COORD_W-1:0]   operand,
   output logic [roi_pkg::SQ_W-1:0]      product
);

   logic [roi_pkg::SQ_W-1:0] product_ff;
   logic [roi_pkg::SQ_W-1:0] product_in;

   assign product_in = operand * operand;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ design/roi_trial_sub.sv @@
// Shared trial subtractor: difference plus a no-borrow flag.
// Serves both the root and the division recurrences; depends on roi_pkg.
module roi_trial_sub (
   input  logic [roi_pkg::UNIT_W-1:0] minuend,
   input  logic [roi_pkg::UNIT_W-1:0] subtrahend,
   output roi_pkg::trial_type         result
);

   logic [roi_pkg::UNIT_W:0] full;

   assign full        = {1'b0, minuend} - {1'b0, subtrahend};
   assign result.diff = full[roi_pkg::UNIT_W-1:0];
   assign result.fits = ~full[roi_pkg::UNIT_W];

endmodule

@@ design/roi_mean_range_occlusion_check_core.sv @@
// ROI mean range occlusion check core: top level with sequencer and datapath.
// Depends on roi_pkg, roi_csr, roi_square, roi_trial_sub and the defines header.
//
// Lidar points arrive one word at a time on the req_ channel. A point whose
// pixel_u and pixel_v lie strictly inside the configured box adds the floor
// root of x*x+y*y+z*z to a running sum, up to 65536 points per cloud. On the
// word flagged final_point the core divides the sum by the count and issues
// one rsp_ word with the mean range, the count, not_occluded and box_empty;
// the accumulators then restart at zero. A point outside the box (or past
// the count limit) is only accepted; a counted point then passes through
// the shared squarer, which takes x, y and z in turn, 24 root steps on the
// shared trial subtractor and an accumulate step. A final word then adds a
// set-up step, 41 division steps on the same trial subtractor and a step
// that loads the result; the division is skipped when no point was counted,
// and loading waits while the previous result is still held on rsp_.
// req_stall is high whenever the sequencer is busy. A result word waits in
// its output register, and the next point is taken meanwhile.
// Registers are at byte addresses 0 to 20, four bytes apart; the two low
// address bits are ignored, and writes to addresses 24 and 28 are dropped.
// No clearing pass is needed after reset.
`include "roi_mean_range_occlusion_check_core_defines.svh"

module roi_mean_range_occlusion_check_core (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [roi_pkg::COORD_W-1:0]        req_point_x,
   input  logic [roi_pkg::COORD_W-1:0]        req_point_y,
   input  logic [roi_pkg::COORD_W-1:0]        req_point_z,
   input  logic [roi_pkg::PIXEL_W-1:0]        req_pixel_u,
   input  logic [roi_pkg::PIXEL_W-1:0]        req_pixel_v,
   input  logic                               req_final_point,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [roi_pkg::RANGE_W-1:0]        rsp_mean_range,
   output logic [roi_pkg::TALLY_W-1:0]        rsp_inside_count,
   output logic                               rsp_not_occluded,
   output logic                               rsp_box_empty,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [roi_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [roi_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [roi_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_ACCUM,
      ST_WRAP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   localparam logic [roi_pkg::STEP_W-1:0] ROOT_LAST = roi_pkg::STEP_W'(roi_pkg::ROOT_STEPS - 1);
   localparam logic [roi_pkg::STEP_W-1:0] DIV_LAST  = roi_pkg::STEP_W'(roi_pkg::DIV_STEPS - 1);
   localparam logic [roi_pkg::STEP_W-1:0] SQ_LAST   = roi_pkg::STEP_W'(3);

   roi_pkg::cfg_type   cfg;
   roi_pkg::trial_type trial;

   state_type                        state_ff, state_in;
   logic [roi_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [roi_pkg::COORD_W-1:0]      x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                             final_ff, final_in;
   logic [roi_pkg::SQ_W-1:0]         sq_ff, sq_in;
   logic [roi_pkg::RANGE_W-1:0]      root_ff, root_in;
   logic [roi_pkg::UNIT_W-1:0]       rem_ff, rem_in;
   logic [roi_pkg::SUM_W-1:0]        dvd_ff, dvd_in;
   logic [roi_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [roi_pkg::TALLY_W-1:0]      tally_ff, tally_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [roi_pkg::RANGE_W-1:0]      rsp_mean_ff, rsp_mean_in;
   logic [roi_pkg::TALLY_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                             rsp_occ_ff, rsp_occ_in;
   logic                             rsp_empty_ff, rsp_empty_in;

   logic                             accept;
   logic                             in_box;
   logic                             slot_free;
   logic [roi_pkg::COORD_W-1:0]      coord_raw;
   logic [roi_pkg::COORD_W-1:0]      coord_mag;
   logic [roi_pkg::SQ_W-1:0]         product;
   logic [roi_pkg::UNIT_W-1:0]       unit_a, unit_b;
   logic [roi_pkg::RANGE_W-1:0]      mean;
   logic [roi_pkg::RANGE_W:0]        mean_plus_tol, exp_plus_tol;
   logic                             above_low, below_high;

   roi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   roi_square u_square (
      .clock   (clock),
      .operand (coord_mag),
      .product (product)
   );

   roi_trial_sub u_trial (
      .minuend    (unit_a),
      .subtrahend (unit_b),
      .result     (trial)
   );

   // Handshake: busy sequencer holds the input, result register parts the output.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_range   = rsp_mean_ff;
   assign rsp_inside_count = rsp_count_ff;
   assign rsp_not_occluded = rsp_occ_ff;
   assign rsp_box_empty    = rsp_empty_ff;

   // Strict box test on the incoming word.
   assign in_box = (req_pixel_u > cfg.box_u_low) && (req_pixel_u < cfg.box_u_high) &&
                   (req_pixel_v > cfg.box_v_low) && (req_pixel_v < cfg.box_v_high);

   // Feed one coordinate magnitude per cycle into the squarer.
   always_comb begin
      case (step_ff[1:0])
         2'd0:    coord_raw = x_ff;
         2'd1:    coord_raw = y_ff;
         default: coord_raw = z_ff;
      endcase
   end
   assign coord_mag = coord_raw[roi_pkg::COORD_W-1] ? (~coord_raw + 24'd1) : coord_raw;

   // Trial subtractor operands: root recurrence or restoring division.
   always_comb begin
      case (state_ff)
         ST_ROOT: begin
            unit_a = {rem_ff[24:0], sq_ff[roi_pkg::SQ_W-1 -: 2]};
            unit_b = {1'b0, root_ff, 2'b01};
         end
         default: begin
            unit_a = {9'd0, rem_ff[16:0], dvd_ff[roi_pkg::SUM_W-1]};
            unit_b = {10'd0, tally_ff};
         end
      endcase
   end

   // Tolerance window, checked without going negative: E-T <= m <= E+T.
   assign mean          = dvd_ff[roi_pkg::RANGE_W-1:0];
   assign mean_plus_tol = {1'b0, mean} + {1'b0, cfg.range_tolerance};
   assign exp_plus_tol  = {1'b0, cfg.expected_distance} + {1'b0, cfg.range_tolerance};
   assign above_low     = mean_plus_tol >= {1'b0, cfg.expected_distance};
   assign below_high    = {1'b0, mean} <= exp_plus_tol;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      final_in     = final_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mean_in  = rsp_mean_ff;
      rsp_count_in = rsp_count_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_empty_in = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_point_x;
               y_in     = req_point_y;
               z_in     = req_point_z;
               final_in = req_final_point;
               step_in  = '0;
               sq_in    = '0;
               if (in_box && (tally_ff < roi_pkg::MAX_POINTS)) begin
                  state_in = ST_SQUARE;
               end else if (req_final_point) begin
                  state_in = ST_WRAP;
               end
            end
         end
         ST_SQUARE: begin
            // product arrives in the cycle after its operand
            if (step_ff != '0) begin
               sq_in = sq_ff + product;
            end
            if (step_ff == SQ_LAST) begin
               state_in = ST_ROOT;
               step_in  = '0;
               rem_in   = '0;
               root_in  = '0;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_ROOT: begin
            sq_in = {sq_ff[roi_pkg::SQ_W-3:0], 2'b00};
            if (trial.fits) begin
               rem_in  = trial.diff;
               root_in = {root_ff[roi_pkg::RANGE_W-2:0], 1'b1};
            end else begin
               rem_in  = unit_a;
               root_in = {root_ff[roi_pkg::RANGE_W-2:0], 1'b0};
            end
            if (step_ff == ROOT_LAST) begin
               state_in = ST_ACCUM;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_ACCUM: begin
            sum_in   = sum_ff + {17'd0, root_ff};
            tally_in = tally_ff + 17'd1;
            state_in = final_ff ? ST_WRAP : ST_IDLE;
         end
         ST_WRAP: begin
            // empty box skips the division altogether
            dvd_in  = sum_ff;
            rem_in  = '0;
            step_in = '0;
            state_in = (tally_ff == '0) ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = trial.fits ? trial.diff : unit_a;
            dvd_in = {dvd_ff[roi_pkg::SUM_W-2:0], trial.fits};
            if (step_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free, then load and restart
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = tally_ff;
               if (tally_ff == '0) begin
                  rsp_mean_in  = '0;
                  rsp_occ_in   = 1'b0;
                  rsp_empty_in = 1'b1;
               end else begin
                  rsp_mean_in  = mean;
                  rsp_occ_in   = above_low && below_high;
                  rsp_empty_in = 1'b0;
               end
               sum_in   = '0;
               tally_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      final_ff     <= final_in;
      sq_ff        <= sq_in;
      root_ff      <= root_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_count_ff <= rsp_count_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_empty_ff <= rsp_empty_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result word appears only out of the finishing state.
   `ROI_ASSERT_NEXT(a_rsp_from_finish, (state_ff != ST_FINISH) && !rsp_valid_ff, !rsp_valid_ff, "result without finishing step")
   // Loading a result restarts both accumulators.
   `ROI_ASSERT_NEXT(a_acc_cleared, (state_ff == ST_FINISH) && slot_free, (sum_ff == '0) && (tally_ff == '0), "accumulators not cleared")
   // The count never passes its limit.
   `ROI_ASSERT_ALWAYS(a_tally_limit, tally_ff <= roi_pkg::MAX_POINTS, "point count above limit")
   // The empty flag agrees with the reported count.
   `ROI_ASSERT_ALWAYS(a_empty_count, !rsp_valid_ff || (rsp_empty_ff == (rsp_count_ff == '0)), "empty flag and count disagree")

endmodule
